// ===== src/ffha_pkg.sv =====
// ffha_pkg: shared types and codes of the first-fit heap allocator
// no dependencies
`default_nettype none

package ffha_pkg;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_OOM     = 2'd1,
    STATUS_UNINIT  = 2'd2,
    STATUS_BADPTR  = 2'd3
  } status_e;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_HEAP_SIZE = 1'b1;

  // sized so that a 32 bit request, header and alignment slack all fit
  localparam int unsigned NeedW = 34;
  localparam int unsigned SplitExtra = 16;

endpackage

`default_nettype wire

// ===== src/ffha_if.sv =====
// ffha_in_if / ffha_out_if: valid/ready channels of the heap allocator
// depends on ffha_pkg
`default_nettype none

interface ffha_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] request_size;
  logic [12:0] alignment;
  logic [63:0] address;

  modport source (output valid, opcode, request_size, alignment, address, input ready);
  modport sink   (input valid, opcode, request_size, alignment, address, output ready);
endinterface

interface ffha_out_if;
  logic                  valid;
  logic                  ready;
  logic [63:0]           result_address;
  ffha_pkg::status_e     status;

  modport source (output valid, result_address, status, input ready);
  modport sink   (input valid, result_address, status, output ready);
endinterface

`default_nettype wire

// ===== src/ffha_size_calc.sv =====
// ffha_size_calc: block length needed for an allocate request
// depends on ffha_pkg
`default_nettype none

module ffha_size_calc #(
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic [31:0]                 request_size_i,
  input  logic [12:0]                 alignment_i,
  output logic [ffha_pkg::NeedW-1:0]  needed_o
);
  import ffha_pkg::*;

  logic [12:0]      mask;
  logic [32:0]      size8;
  logic [NeedW-1:0] sum;

  always_comb begin
    // alignment minus one smeared right gives the mask of the next power of two
    mask = (alignment_i == 13'd0) ? 13'd0 : alignment_i - 13'd1;
    mask = mask | (mask >> 1);
    mask = mask | (mask >> 2);
    mask = mask | (mask >> 4);
    mask = mask | (mask >> 8);
    size8 = (33'(request_size_i) + 33'd7) & ~33'd7;
    sum = NeedW'(size8) + NeedW'(HEADER_BYTES) + NeedW'(mask);
    needed_o = sum & ~NeedW'(mask);
  end

endmodule

`default_nettype wire

// ===== src/first_fit_heap_allocator.sv =====
// first_fit_heap_allocator: first-fit allocator over an address-ordered block table
// depends on ffha_pkg, ffha_if, ffha_size_calc
//
// The block table sits in one synchronous memory (one read, one write port) and
// is walked one entry at a time. An allocate reads each entry that it visits and,
// when a split or a merge shifts the tail of the table, moves each entry of that
// tail; a free compares the entries in order. With the default 64 entries the
// worst case is a full table in which every free block at the head is merged
// with its successor and each merge shifts the whole tail. A finished result
// waits in the output register while the next transfer is accepted.
`default_nettype none

module first_fit_heap_allocator #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned OFFSET_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffha_in_if.sink     req,
  ffha_out_if.source  rsp,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);
  import ffha_pkg::*;

  localparam int unsigned IW   = $clog2(MAX_BLOCKS);
  localparam int unsigned CNTW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned LW   = OFFSET_BITS + 1;
  localparam int unsigned CW   = (LW > NeedW) ? LW : NeedW;
  localparam int unsigned SW   = (LW > 33) ? LW : 33;
  localparam int unsigned EW   = OFFSET_BITS + LW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_A_LD  = 4'd1;
  localparam logic [3:0] S_A_CHK = 4'd2;
  localparam logic [3:0] S_A_NXT = 4'd3;
  localparam logic [3:0] S_SD_RD = 4'd4;
  localparam logic [3:0] S_SD_WR = 4'd5;
  localparam logic [3:0] S_SU_RD = 4'd6;
  localparam logic [3:0] S_SU_WR = 4'd7;
  localparam logic [3:0] S_F_CHK = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // table entry: {start, length, free}
  logic [EW-1:0] mem [MAX_BLOCKS];
  logic [EW-1:0] rdata_q;
  logic [IW-1:0] raddr, waddr;
  logic          we;
  logic [EW-1:0] wdata;

  logic [3:0]             state_q, state_d;
  logic [IW-1:0]          idx_q, idx_d, j_q, j_d;
  logic [CNTW-1:0]        cnt_q, cnt_d;
  logic [NeedW-1:0]       need_q, need_d, need_calc;
  logic [CW-1:0]          need_x;
  logic [63:0]            addr_q, addr_d, base_h_q, base_h_d;
  logic [OFFSET_BITS-1:0] cur_start_q, cur_start_d, new_start_q, new_start_d;
  logic [LW-1:0]          cur_len_q, cur_len_d, new_len_q, new_len_d;
  logic                   cur_free_q, cur_free_d;
  logic [63:0]            res_addr_q, res_addr_d, out_addr_q;
  status_e                res_status_q, res_status_d, out_status_q;
  logic                   out_valid_q, out_valid_d;
  logic                   in_xfer, out_load;

  logic [OFFSET_BITS-1:0] rd_start;
  logic [LW-1:0]          rd_len;
  logic                   rd_free;
  logic [CNTW-1:0]        idx_p1, j_p1;
  logic [LW-1:0]          left, merged;
  logic [SW-1:0]          sz_w, sz_lim, sz_sat;

  ffha_size_calc #(.HEADER_BYTES(HEADER_BYTES)) u_size (
    .request_size_i (req.request_size),
    .alignment_i    (req.alignment),
    .needed_o       (need_calc)
  );

  assign rd_free  = rdata_q[0];
  assign rd_len   = rdata_q[LW:1];
  assign rd_start = rdata_q[EW-1:LW+1];
  assign idx_p1   = CNTW'(idx_q) + CNTW'(1);
  assign j_p1     = CNTW'(j_q) + CNTW'(1);
  assign need_x   = CW'(need_q);
  assign left     = cur_len_q - need_x[LW-1:0];
  assign merged   = cur_len_q + rd_len;

  assign sz_w   = SW'(cfg_wdata_i[32:0]);
  assign sz_lim = SW'(1) << OFFSET_BITS;
  assign sz_sat = (sz_w > sz_lim) ? sz_lim : sz_w;

  assign req.ready = (state_q == S_IDLE);
  assign in_xfer   = req.valid && (state_q == S_IDLE);
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    j_d          = j_q;
    cnt_d        = cnt_q;
    need_d       = need_q;
    addr_d       = addr_q;
    base_h_d     = base_h_q;
    cur_start_d  = cur_start_q;
    cur_len_d    = cur_len_q;
    cur_free_d   = cur_free_q;
    new_start_d  = new_start_q;
    new_len_d    = new_len_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    raddr        = '0;
    waddr        = idx_q;
    we           = 1'b0;
    wdata        = {cur_start_q, cur_len_q, 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          need_d       = need_calc;
          addr_d       = req.address;
          idx_d        = '0;
          res_addr_d   = '0;
          res_status_d = STATUS_OK;
          if (req.opcode == OP_ALLOC) begin
            if (cnt_q == '0) begin
              res_status_d = STATUS_UNINIT;
              state_d      = S_DONE;
            end else begin
              state_d = S_A_LD;
            end
          end else if (req.address == 64'd0) begin
            state_d = S_DONE;
          end else if (cnt_q == '0) begin
            res_status_d = STATUS_UNINIT;
            state_d      = S_DONE;
          end else begin
            state_d = S_F_CHK;
          end
        end
      end
      S_A_LD: begin
        cur_start_d = rd_start;
        cur_len_d   = rd_len;
        cur_free_d  = rd_free;
        state_d     = S_A_CHK;
      end
      S_A_CHK: begin
        if (cur_free_q && (CW'(cur_len_q) >= CW'(need_q))) begin
          res_addr_d   = base_h_q + 64'(cur_start_q);
          res_status_d = STATUS_OK;
          we           = 1'b1;
          if ((left >= LW'(HEADER_BYTES + SplitExtra)) && (cnt_q < CNTW'(MAX_BLOCKS))) begin
            wdata       = {cur_start_q, need_x[LW-1:0], 1'b0};
            new_start_d = cur_start_q + need_x[OFFSET_BITS-1:0];
            new_len_d   = left;
            j_d         = cnt_q[IW-1:0];
            state_d     = S_SU_RD;
          end else begin
            state_d = S_DONE;
          end
        end else if (idx_p1 >= cnt_q) begin
          res_status_d = STATUS_OOM;
          state_d      = S_DONE;
        end else if (cur_free_q) begin
          raddr   = idx_q + IW'(1);
          state_d = S_A_NXT;
        end else begin
          raddr   = idx_q + IW'(1);
          idx_d   = idx_q + IW'(1);
          state_d = S_A_LD;
        end
      end
      S_A_NXT: begin
        if (rd_free) begin
          // lazy merge of a short free block with its free successor
          cur_len_d = merged;
          we        = 1'b1;
          wdata     = {cur_start_q, merged, 1'b1};
          j_d       = idx_q + IW'(1);
          state_d   = S_SD_RD;
        end else begin
          idx_d       = idx_q + IW'(1);
          cur_start_d = rd_start;
          cur_len_d   = rd_len;
          cur_free_d  = rd_free;
          state_d     = S_A_CHK;
        end
      end
      S_SD_RD: begin
        if (j_p1 < cnt_q) begin
          raddr   = j_q + IW'(1);
          state_d = S_SD_WR;
        end else begin
          cnt_d   = cnt_q - CNTW'(1);
          state_d = S_A_CHK;
        end
      end
      S_SD_WR: begin
        we      = 1'b1;
        waddr   = j_q;
        wdata   = rdata_q;
        j_d     = j_q + IW'(1);
        state_d = S_SD_RD;
      end
      S_SU_RD: begin
        if (CNTW'(j_q) > idx_p1) begin
          raddr   = j_q - IW'(1);
          state_d = S_SU_WR;
        end else begin
          we      = 1'b1;
          waddr   = j_q;
          wdata   = {new_start_q, new_len_q, 1'b1};
          cnt_d   = cnt_q + CNTW'(1);
          state_d = S_DONE;
        end
      end
      S_SU_WR: begin
        we      = 1'b1;
        waddr   = j_q;
        wdata   = rdata_q;
        j_d     = j_q - IW'(1);
        state_d = S_SU_RD;
      end
      S_F_CHK: begin
        if (base_h_q + 64'(rd_start) == addr_q) begin
          we           = 1'b1;
          wdata        = {rd_start, rd_len, 1'b1};
          res_status_d = STATUS_OK;
          state_d      = S_DONE;
        end else if (idx_p1 >= cnt_q) begin
          res_status_d = STATUS_BADPTR;
          state_d      = S_DONE;
        end else begin
          raddr = idx_q + IW'(1);
          idx_d = idx_q + IW'(1);
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // configuration writes must arrive only while idle; the block itself does not enforce this
    if (cfg_we_i) begin
      if (cfg_idx_i == REG_HEAP_BASE) begin
        base_h_d = cfg_wdata_i + 64'(HEADER_BYTES);
      end else begin
        cnt_d = (sz_sat != '0) ? CNTW'(1) : '0;
        we    = 1'b1;
        waddr = '0;
        wdata = {{OFFSET_BITS{1'b0}}, sz_sat[LW-1:0], 1'b1};
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      base_h_q    <= 64'(HEADER_BYTES);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      base_h_q    <= base_h_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    j_q          <= j_d;
    need_q       <= need_d;
    addr_q       <= addr_d;
    cur_start_q  <= cur_start_d;
    cur_len_q    <= cur_len_d;
    cur_free_q   <= cur_free_d;
    new_start_q  <= new_start_d;
    new_len_q    <= new_len_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
    end
  end

  assign rsp.valid          = out_valid_q;
  assign rsp.result_address = out_addr_q;
  assign rsp.status         = out_status_q;

endmodule

`default_nettype wire
